>>> rtl/sliding_window_median_unit_assert.svh
// Assertion macros for the sliding window median unit.
// Depends on nothing; included by the top level.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SWM_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define SWM_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/swm_pkg.sv
// Shared constants and types for the sliding window median unit.
// Depends on nothing.
`default_nettype none
package swm_pkg;
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = IDX_W + 1;
    localparam int OUT_W       = SAMPLE_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]       t_median;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [IDX_W-1:0]              t_index;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic remove;
        logic insert;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

>>> rtl/swm_in_if.sv
// Input channel of the median unit: sample word with restart flag.
// Depends on swm_pkg.
`default_nettype none
interface swm_in_if;
    logic               valid;
    logic               ready;
    swm_pkg::t_sample   sample;
    logic               restart;
    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface
`default_nettype wire

>>> rtl/swm_out_if.sv
// Output channel of the median unit: doubled median word.
// Depends on swm_pkg.
`default_nettype none
interface swm_out_if;
    logic               valid;
    logic               ready;
    swm_pkg::t_median   median_doubled;
    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface
`default_nettype wire

>>> rtl/sliding_window_median_unit.sv
// Running median filter over the last k signed samples (k = window_size, 1..64,
// zero read as 1, larger values as 64). The sequencer steps each word through
// accept (with the registered ring read of the oldest word), remove from the
// sorted cell row, insert and emit; the next word is accepted only after emit.
// A result still waiting in the output register holds the next word in emit
// until the register frees. No result is given until k words have
// arrived since the last restart or size write. The result is twice the median,
// exact with one fractional bit. Depends on swm_pkg and the interfaces.
`default_nettype none
`include "sliding_window_median_unit_assert.svh"
module sliding_window_median_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    swm_in_if.sink           i_in,
    swm_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import swm_pkg::*;

    localparam logic ADDR_WINDOW_SIZE = 1'b0;

    logic [6:0] r_window_size;
    logic       cfg_wr;
    t_count     k_eff;
    t_cmd       cmd;
    t_stat      stat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_WINDOW_SIZE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= 7'd3;
        end else if (cfg_wr) begin
            r_window_size <= pwdata[6:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_WINDOW_SIZE) ? {25'd0, r_window_size} : '0;

    // effective window length
    always_comb begin
        if (r_window_size == '0) begin
            k_eff = t_count'(1);
        end else if (r_window_size > t_count'(WINDOW_MAX)) begin
            k_eff = t_count'(WINDOW_MAX);
        end else begin
            k_eff = t_count'(r_window_size);
        end
    end

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_in.sample),
        .i_restart   (i_in.restart),
        .i_k         (k_eff),
        .i_clear     (cfg_wr),
        .o_valid     (o_out.valid),
        .o_median    (o_out.median_doubled),
        .i_out_ready (o_out.ready)
    );

    // one word in flight: ready drops right after an accept
    `SWM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // a result is only loaded with a full window
    `SWM_ASSERT_IMPLY(a_emit_full, i_clk, i_rst_n, cmd.emit, stat.full)
    // a fresh result never overwrites one still waiting
    `SWM_ASSERT_IMPLY(a_no_overrun, i_clk, i_rst_n, cmd.emit, !o_out.valid || o_out.ready)
endmodule
`default_nettype wire

>>> rtl/swm_ctrl.sv
// Sequencer of the median unit: steps one sample through remove, insert, emit.
// Depends on swm_pkg.
`default_nettype none
module swm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire swm_pkg::t_stat i_stat,
    output swm_pkg::t_cmd      o_cmd
);
    import swm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REMOVE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                o_cmd.remove = i_stat.full;
                n_state      = ST_INSERT;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stat.full) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

>>> rtl/swm_datapath.sv
// Datapath of the median unit: arrival ring memory, sorted cell row, output word.
// Depends on swm_pkg.
`default_nettype none
module swm_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire swm_pkg::t_cmd    i_cmd,
    output swm_pkg::t_stat        o_stat,
    input  wire swm_pkg::t_sample i_sample,
    input  wire logic             i_restart,
    input  wire swm_pkg::t_count  i_k,
    input  wire logic             i_clear,
    output logic                  o_valid,
    output swm_pkg::t_median      o_median,
    input  wire logic             i_out_ready
);
    import swm_pkg::*;

    t_sample r_ring [WINDOW_MAX];
    t_sample r_cell [WINDOW_MAX];
    t_sample n_cell [WINDOW_MAX];
    t_sample r_sample, r_old;
    t_count  r_fill;
    t_index  r_ptr;
    logic    r_valid;
    t_median r_median;

    logic    restart_now;
    t_count  adj_fill, ins_cnt;
    t_index  adj_ptr, lo_idx, hi_idx;
    logic [WINDOW_MAX-1:0] rm_after, gt;
    t_median med;

    // window emptied by restart or by stale counts after a size change
    assign restart_now = i_restart || (r_fill > i_k) || ({1'b0, r_ptr} >= i_k);
    assign adj_fill    = restart_now ? '0 : r_fill;
    assign adj_ptr     = restart_now ? '0 : r_ptr;
    assign ins_cnt     = (r_fill == i_k) ? i_k - t_count'(1) : r_fill;

    // removal: everything from the first match onward moves down
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            rm_after[i] = ((r_cell[i] == r_old) && (t_count'(i) < i_k))
                          || ((i > 0) ? rm_after[(i > 0) ? i - 1 : 0] : 1'b0);
            gt[i] = (t_count'(i) < ins_cnt) && (r_cell[i] > r_sample);
        end
    end

    // next value of each sorted cell
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.remove) begin
                if (rm_after[i] && (t_count'(i + 1) < i_k) && (i < WINDOW_MAX - 1)) begin
                    n_cell[i] = r_cell[(i < WINDOW_MAX - 1) ? i + 1 : i];
                end
            end else if (i_cmd.insert) begin
                if (t_count'(i) > ins_cnt) begin
                    n_cell[i] = r_cell[i];
                end else if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end else if ((t_count'(i) < ins_cnt) && !gt[i]) begin
                    n_cell[i] = r_cell[i];
                end else begin
                    n_cell[i] = r_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // arrival ring memory, registered read of the oldest word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old    <= r_ring[adj_ptr];
            r_sample <= i_sample;
        end
        if (i_cmd.insert) begin
            r_ring[r_ptr] <= r_sample;
        end
    end

    // fill count and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.accept) begin
            r_fill <= adj_fill;
            r_ptr  <= adj_ptr;
        end else if (i_cmd.insert) begin
            r_ptr <= ({1'b0, r_ptr} + t_count'(1) >= i_k) ? '0 : r_ptr + t_index'(1);
            if (r_fill != i_k) begin
                r_fill <= r_fill + t_count'(1);
            end
        end
    end

    // median from the middle cells
    assign hi_idx = t_index'(i_k >> 1);
    assign lo_idx = i_k[0] ? hi_idx : hi_idx - t_index'(1);
    assign med    = t_median'(r_cell[lo_idx]) + t_median'(r_cell[hi_idx]);

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_median <= med;
        end
    end

    assign o_valid         = r_valid;
    assign o_median        = r_median;
    assign o_stat.full     = (r_fill == i_k);
    assign o_stat.out_free = !r_valid || i_out_ready;
endmodule
`default_nettype wire
